// ===== rtl/rmth_pkg.sv =====
// Shared types for the running median block: sequencer states, chain commands and cell links.
`default_nettype none
package rmth_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIRST,
		ST_SECOND,
		ST_MEDIAN
	} state_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_REPLACE
	} chain_op_t;

	// Flags that one cell hands to the next one down the chain.
	typedef struct packed {
		logic keep_ins;
		logic keep_rep;
	} link_t;

endpackage
`default_nettype wire

// ===== rtl/rmth_sample_if.sv =====
// Input channel carrying one sample per beat.
`default_nettype none
interface rmth_sample_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] sample_value;

	modport source (output valid, output sample_value, input ready);
	modport sink (input valid, input sample_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/rmth_result_if.sv =====
// Output channel carrying the median, the fill count and the drop flag per beat.
`default_nettype none
interface rmth_result_if #(
	parameter int VALUE_WIDTH = 32,
	parameter int COUNT_WIDTH = 11
);
	logic                        valid;
	logic                        ready;
	logic signed [VALUE_WIDTH:0] median_half_units;
	logic [COUNT_WIDTH-1:0]      stored_count;
	logic                        dropped;

	modport source (output valid, output median_half_units, output stored_count,
		output dropped, input ready);
	modport sink (input valid, input median_half_units, input stored_count,
		input dropped, output ready);
endinterface
`default_nettype wire

// ===== rtl/rmth_cell.sv =====
// One position of a sorted chain: holds a value and shifts it with its neighbours.
`default_nettype none
module rmth_cell import rmth_pkg::*; #(
	parameter int VALUE_WIDTH = 32,
	parameter int COUNT_WIDTH = 10,
	parameter int INDEX       = 0,
	parameter bit IS_MAX      = 1'b1
) (
	input  logic                   clk,
	input  chain_op_t              op,
	input  logic [VALUE_WIDTH-1:0] key,
	input  logic [COUNT_WIDTH-1:0] count,
	input  logic [VALUE_WIDTH-1:0] prev_data,
	input  link_t                  prev_link,
	input  logic [VALUE_WIDTH-1:0] next_data,
	output logic [VALUE_WIDTH-1:0] data,
	output link_t                  link
);

	logic [VALUE_WIDTH-1:0] data_q;
	logic [VALUE_WIDTH-1:0] data_d;
	logic                   occupied;
	logic                   next_occupied;
	logic                   own_ranks;
	logic                   next_ranks;

	assign occupied      = count > COUNT_WIDTH'(INDEX);
	assign next_occupied = count > COUNT_WIDTH'(INDEX + 1);

	// A value ranks at or above the key when it belongs nearer the top of the chain.
	always_comb begin
		if (IS_MAX) begin
			own_ranks  = $signed(data_q) >= $signed(key);
			next_ranks = $signed(next_data) >= $signed(key);
		end else begin
			own_ranks  = $signed(data_q) <= $signed(key);
			next_ranks = $signed(next_data) <= $signed(key);
		end
	end

	assign link.keep_ins = occupied && own_ranks;
	assign link.keep_rep = next_occupied && next_ranks;

	// Insert: cells below the insertion point take their upper neighbour's value.
	// Replace: the top leaves, cells above the key's place move up by one.
	always_comb begin
		case (op)
			OP_INSERT: begin
				if (link.keep_ins)
					data_d = data_q;
				else if (prev_link.keep_ins)
					data_d = key;
				else
					data_d = prev_data;
			end
			OP_REPLACE: begin
				if (link.keep_rep)
					data_d = next_data;
				else if (prev_link.keep_rep)
					data_d = key;
				else
					data_d = data_q;
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule
`default_nettype wire

// ===== rtl/rmth_chain.sv =====
// A row of cells that keeps one half of the samples sorted, best value at position zero.
`default_nettype none
module rmth_chain import rmth_pkg::*; #(
	parameter int DEPTH       = 512,
	parameter int VALUE_WIDTH = 32,
	parameter int COUNT_WIDTH = 10,
	parameter bit IS_MAX      = 1'b1
) (
	input  logic                   clk,
	input  chain_op_t              op,
	input  logic [VALUE_WIDTH-1:0] key,
	input  logic [COUNT_WIDTH-1:0] count,
	output logic [VALUE_WIDTH-1:0] top
);

	logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
	link_t                  cell_link [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] prev_data;
		logic [VALUE_WIDTH-1:0] next_data;
		link_t                  prev_link;

		// The place above the first cell acts as one that always keeps its value.
		if (i == 0) begin : g_first
			assign prev_data = '0;
			assign prev_link = '{keep_ins: 1'b1, keep_rep: 1'b1};
		end else begin : g_inner
			assign prev_data = cell_data[i-1];
			assign prev_link = cell_link[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_data = '0;
		end else begin : g_body
			assign next_data = cell_data[i+1];
		end

		rmth_cell #(
			.VALUE_WIDTH (VALUE_WIDTH),
			.COUNT_WIDTH (COUNT_WIDTH),
			.INDEX       (i),
			.IS_MAX      (IS_MAX)
		) u_cell (
			.clk       (clk),
			.op        (op),
			.key       (key),
			.count     (count),
			.prev_data (prev_data),
			.prev_link (prev_link),
			.next_data (next_data),
			.data      (cell_data[i]),
			.link      (cell_link[i])
		);
	end

	assign top = cell_data[0];

endmodule
`default_nettype wire

// ===== rtl/running_median_two_heaps.sv =====
// A sample goes from idle to FIRST, to SECOND when a value crosses halves, and then to MEDIAN,
// which loads the registered result once the output is free; the next sample is taken only after that.
// Each half is a sorted row of cells that inserts a value or replaces its top.
// Reset clears both counts, the drop flag, the sequencer and the output valid flag; the cells are not reset.
// The block accepts a sample as soon as reset is released.
`default_nettype none
module running_median_two_heaps import rmth_pkg::*; #(
	parameter int HALF_CAPACITY = 512,
	parameter int VALUE_WIDTH   = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	rmth_sample_if.sink   samples,
	rmth_result_if.source results
);

	localparam int CW = $clog2(HALF_CAPACITY + 1);
	localparam int TW = $clog2(2 * HALF_CAPACITY + 1);
	localparam logic [TW-1:0] FULL = TW'(2 * HALF_CAPACITY);

	state_t                  state_q;
	state_t                  state_d;
	logic [VALUE_WIDTH-1:0]  v_q;
	logic [VALUE_WIDTH-1:0]  x_q;
	logic [VALUE_WIDTH-1:0]  x_d;
	logic                    to_upper_q;
	logic                    to_upper_d;
	logic                    load_x;
	logic [CW-1:0]           lc_q;
	logic [CW-1:0]           uc_q;
	logic                    lc_inc;
	logic                    uc_inc;
	logic                    dropped_q;
	logic                    set_drop;
	logic [VALUE_WIDTH:0]    median_q;
	logic [VALUE_WIDTH:0]    median_d;
	logic                    load_result;
	logic [TW-1:0]           total;
	logic                    go_low;
	chain_op_t               lo_op;
	chain_op_t               up_op;
	logic [VALUE_WIDTH-1:0]  lo_key;
	logic [VALUE_WIDTH-1:0]  up_key;
	logic [VALUE_WIDTH-1:0]  lo_top;
	logic [VALUE_WIDTH-1:0]  up_top;
	logic                    res_valid_q;
	logic [VALUE_WIDTH:0]    res_median_q;
	logic [TW-1:0]           res_count_q;
	logic                    res_dropped_q;
	logic                    out_free;
	logic                    accept;

	assign accept   = samples.valid && samples.ready;
	assign out_free = !res_valid_q || results.ready;
	assign total    = TW'(lc_q) + TW'(uc_q);
	assign go_low   = $signed({v_q, 1'b0}) <= $signed(median_q);

	always_comb begin
		if (lc_q == uc_q)
			median_d = {lo_top[VALUE_WIDTH-1], lo_top} + {up_top[VALUE_WIDTH-1], up_top};
		else if (lc_q > uc_q)
			median_d = {lo_top, 1'b0};
		else
			median_d = {up_top, 1'b0};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = ST_FIRST;
			end
			ST_FIRST: begin
				if (total != FULL && total != '0 && go_low && lc_q > uc_q)
					state_d = ST_SECOND;
				else if (total != FULL && total != '0 && !go_low && uc_q > lc_q)
					state_d = ST_SECOND;
				else
					state_d = ST_MEDIAN;
			end
			ST_SECOND: begin
				state_d = ST_MEDIAN;
			end
			ST_MEDIAN: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		lo_op       = OP_HOLD;
		up_op       = OP_HOLD;
		lo_key      = v_q;
		up_key      = v_q;
		lc_inc      = 1'b0;
		uc_inc      = 1'b0;
		x_d         = v_q;
		to_upper_d  = 1'b0;
		load_x      = 1'b0;
		set_drop    = 1'b0;
		load_result = 1'b0;
		case (state_q)
			ST_FIRST: begin
				if (total == FULL) begin
					set_drop = 1'b1;
				end else if (total == '0) begin
					lo_op  = OP_INSERT;
					lc_inc = 1'b1;
				end else if (go_low) begin
					if (lc_q > uc_q) begin
						// The lower half already holds one more: the larger of its top and the new value moves up.
						load_x     = 1'b1;
						to_upper_d = 1'b1;
						if ($signed(lo_top) > $signed(v_q)) begin
							lo_op = OP_REPLACE;
							x_d   = lo_top;
						end
					end else begin
						lo_op  = OP_INSERT;
						lc_inc = 1'b1;
					end
				end else begin
					if (uc_q > lc_q) begin
						load_x     = 1'b1;
						to_upper_d = 1'b0;
						if ($signed(up_top) < $signed(v_q)) begin
							up_op = OP_REPLACE;
							x_d   = up_top;
						end
					end else begin
						up_op  = OP_INSERT;
						uc_inc = 1'b1;
					end
				end
			end
			ST_SECOND: begin
				lo_key = x_q;
				up_key = x_q;
				if (to_upper_q) begin
					up_op  = OP_INSERT;
					uc_inc = 1'b1;
				end else begin
					lo_op  = OP_INSERT;
					lc_inc = 1'b1;
				end
			end
			ST_MEDIAN: begin
				load_result = out_free;
			end
			default: begin
				load_result = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lc_q        <= '0;
			uc_q        <= '0;
			dropped_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (lc_inc)
				lc_q <= lc_q + CW'(1);
			if (uc_inc)
				uc_q <= uc_q + CW'(1);
			if (accept)
				dropped_q <= 1'b0;
			else if (set_drop)
				dropped_q <= 1'b1;
			if (load_result)
				res_valid_q <= 1'b1;
			else if (results.ready)
				res_valid_q <= 1'b0;
		end
	end

	// Payload registers need no reset; the median is only compared once a value is held.
	always_ff @(posedge clk) begin
		if (accept)
			v_q <= samples.sample_value;
		if (load_x) begin
			x_q        <= x_d;
			to_upper_q <= to_upper_d;
		end
		if (load_result) begin
			median_q      <= median_d;
			res_median_q  <= median_d;
			res_count_q   <= total;
			res_dropped_q <= dropped_q;
		end
	end

	rmth_chain #(
		.DEPTH       (HALF_CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH),
		.COUNT_WIDTH (CW),
		.IS_MAX      (1'b1)
	) u_lower (
		.clk   (clk),
		.op    (lo_op),
		.key   (lo_key),
		.count (lc_q),
		.top   (lo_top)
	);

	rmth_chain #(
		.DEPTH       (HALF_CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH),
		.COUNT_WIDTH (CW),
		.IS_MAX      (1'b0)
	) u_upper (
		.clk   (clk),
		.op    (up_op),
		.key   (up_key),
		.count (uc_q),
		.top   (up_top)
	);

	assign samples.ready             = state_q == ST_IDLE;
	assign results.valid             = res_valid_q;
	assign results.median_half_units = res_median_q;
	assign results.stored_count      = res_count_q;
	assign results.dropped           = res_dropped_q;

endmodule
`default_nettype wire

// ===== rtl/rmth_checker.sv =====
// Port-level checks for the running median block, bound to its top level.
`default_nettype none
module rmth_checker #(
	parameter int HALF_CAPACITY = 512,
	parameter int VALUE_WIDTH   = 32
) (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [VALUE_WIDTH:0]        out_median,
	input wire logic [$clog2(2*HALF_CAPACITY+1)-1:0] out_count,
	input wire logic                        out_dropped
);

	localparam int TW = $clog2(2 * HALF_CAPACITY + 1);
	localparam logic [TW-1:0] FULL = TW'(2 * HALF_CAPACITY);

	// Only one sample is in flight, so the input closes right after a beat.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input stayed open after a beat");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_dropped |-> out_count == FULL)
		else $error("sample dropped while the store had room");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_count != '0 && out_count <= FULL)
		else $error("stored count out of range");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_median)
			&& $stable(out_count) && $stable(out_dropped))
		else $error("result changed while stalled");

endmodule

bind running_median_two_heaps rmth_checker #(
	.HALF_CAPACITY (HALF_CAPACITY),
	.VALUE_WIDTH   (VALUE_WIDTH)
) u_rmth_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.out_median  (results.median_half_units),
	.out_count   (results.stored_count),
	.out_dropped (results.dropped)
);
`default_nettype wire

// ===== test/running_median_two_heaps_tb.sv =====
// Self-checking testbench for the two-heap running median block, with a sorted-multiset predictor.
`timescale 1ns / 100ps
module running_median_two_heaps_tb;
	import rmth_pkg::*;

	localparam int HALF_CAPACITY      = 512;
	localparam int VALUE_WIDTH        = 32;
	localparam int STORE_DEPTH        = 2 * HALF_CAPACITY;
	localparam int COUNT_WIDTH        = 11;
	localparam int OUTPUT_HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT     = 4000;
	localparam int END_SETTLE_CYCLES  = 12;
	localparam int MAX_REPORTS        = 10;

	localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [VALUE_WIDTH:0] median_half_units;
		logic [COUNT_WIDTH-1:0]      stored_count;
		logic                        dropped;
	} median_beat_t;

	logic clk;
	logic arst_n;

	rmth_sample_if #(.VALUE_WIDTH(VALUE_WIDTH)) sample_ch ();
	rmth_result_if #(.VALUE_WIDTH(VALUE_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) result_ch ();

	running_median_two_heaps #(
		.HALF_CAPACITY(HALF_CAPACITY),
		.VALUE_WIDTH  (VALUE_WIDTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(sample_ch),
		.results(result_ch)
	);

	// Every value the block should hold, kept in ascending order.
	longint       held_values[$];
	median_beat_t expected_results[$];
	int           mismatch_count;
	int           quiet_cycles;
	bit           sender_gaps_on;
	bit           receiver_gaps_on;
	bit           hold_toggle;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The lower half's top and the upper half's bottom always straddle the middle of the
	// sorted multiset, so the median in half units is read straight from the sorted list.
	function automatic logic signed [VALUE_WIDTH:0] median_of_held();
		int     n;
		longint m;
		n = held_values.size();
		if (n == 0)
			m = 0;
		else if (n % 2 == 1)
			m = 2 * held_values[n / 2];
		else
			m = held_values[n / 2 - 1] + held_values[n / 2];
		return m[VALUE_WIDTH:0];
	endfunction

	function automatic void record_sample(input logic signed [VALUE_WIDTH-1:0] v);
		median_beat_t beat;
		int           lo;
		int           hi;
		int           mid;
		longint       value;
		value = v;
		if (held_values.size() >= STORE_DEPTH) begin
			beat.dropped = 1'b1;
		end else begin
			lo = 0;
			hi = held_values.size();
			while (lo < hi) begin
				mid = (lo + hi) / 2;
				if (held_values[mid] <= value)
					lo = mid + 1;
				else
					hi = mid;
			end
			held_values.insert(lo, value);
			beat.dropped = 1'b0;
		end
		beat.median_half_units = median_of_held();
		beat.stored_count = COUNT_WIDTH'(held_values.size());
		expected_results.push_back(beat);
	endfunction

	// A blend of wide values, a narrow band full of repeats, both rails and values around the median.
	function automatic logic signed [VALUE_WIDTH-1:0] random_sample();
		logic signed [VALUE_WIDTH:0] centre;
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom;
			4, 5: return $signed($urandom_range(20)) - 10;
			6: return VALUE_MAX - $urandom_range(3);
			7: return VALUE_MIN + $urandom_range(3);
			default: begin
				centre = median_of_held() >>> 1;
				return centre[VALUE_WIDTH-1:0] + $urandom_range(4) - 2;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: mismatch: %s", $realtime, what);
	endtask

	task automatic check_result_beat();
		median_beat_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("result beat with nothing outstanding: median %0d count %0d dropped %0b",
				result_ch.median_half_units, result_ch.stored_count, result_ch.dropped));
		end else begin
			want = expected_results.pop_front();
			if (result_ch.median_half_units !== want.median_half_units)
				report_mismatch($sformatf("median_half_units expected %0d actual %0d",
					want.median_half_units, result_ch.median_half_units));
			if (result_ch.stored_count !== want.stored_count)
				report_mismatch($sformatf("stored_count expected %0d actual %0d",
					want.stored_count, result_ch.stored_count));
			if (result_ch.dropped !== want.dropped)
				report_mismatch($sformatf("dropped expected %0b actual %0b",
					want.dropped, result_ch.dropped));
		end
	endtask

	// Valid is left high after a beat so that back-to-back samples need only one assignment per edge.
	task automatic send_sample(input logic signed [VALUE_WIDTH-1:0] v);
		while (sender_gaps_on && $urandom_range(99) < 8) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample_value <= v;
		do @(posedge clk); while (!sample_ch.ready);
		record_sample(v);
	endtask

	task automatic sender_quiet();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_for_results();
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// First sample, a second one below it that must still be compared, and a tie with the median.
	task automatic test_opening_samples();
		send_sample(32'sd7);
		send_sample(-32'sd3);
		send_sample(32'sd2);
	endtask

	// Enough of each rail to drive the median to both ends, then the sign and bit pattern corners.
	task automatic test_value_extremes();
		repeat (5) send_sample(VALUE_MAX);
		repeat (9) send_sample(VALUE_MIN);
		send_sample(32'sd0);
		send_sample(-32'sd1);
		send_sample(32'sd1);
		send_sample(32'sh5555_5555);
		send_sample(32'shAAAA_AAAA);
	endtask

	task automatic test_random_samples(input int count);
		for (int i = 0; i < count; i++) begin
			// A stretch in which neither side leaves a gap.
			sender_gaps_on = !(i >= count / 4 && i < count / 2);
			receiver_gaps_on = sender_gaps_on;
			send_sample(random_sample());
		end
		sender_gaps_on = 1'b1;
		receiver_gaps_on = 1'b1;
	endtask

	// The receiver stops taking beats while samples keep coming, so the block backs up to its input.
	task automatic test_output_hold();
		hold_toggle = !hold_toggle;
		repeat (40) send_sample(random_sample());
	endtask

	task automatic test_sender_pause();
		sender_quiet();
		wait_for_results();
		repeat (30) send_sample(random_sample());
	endtask

	initial begin : result_sink
		int hold_left;
		bit hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready)
				check_result_beat();
			if (hold_seen != hold_toggle) begin
				hold_seen = hold_toggle;
				hold_left = OUTPUT_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= !(receiver_gaps_on && $urandom_range(99) < 8);
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("running_median_two_heaps verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		mismatch_count = 0;
		quiet_cycles = 0;
		sender_gaps_on = 1'b1;
		receiver_gaps_on = 1'b1;
		hold_toggle = 1'b0;
		arst_n <= 1'b0;
		sample_ch.valid <= 1'b0;
		sample_ch.sample_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_opening_samples();
		test_value_extremes();
		test_random_samples(460);
		test_output_hold();
		test_sender_pause();

		sender_quiet();
		wait_for_results();
		repeat (END_SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("running_median_two_heaps verification clean");
		else
			$display("running_median_two_heaps verification failed");
		$finish;
	end

endmodule
